// ===== rtl/mdk_pkg.sv =====
// shared types, register codes and constants for the mecanum drive kinematics block
package mdk_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_SCALE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVER_ARM_MM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_VX     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_VY     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_YAW    = 3'd5;

    // register reset values
    localparam logic [19:0] RST_WHEEL_SCALE  = 20'd65536;
    localparam logic [19:0] RST_YAW_GAIN     = 20'd655360;
    localparam logic [11:0] RST_LEVER_ARM_MM = 12'd100;
    localparam logic [14:0] RST_LIMIT        = 15'd32767;

    // ceil(2^35 / 125): x / 125 is (x * RECIP_125) >> 35, x / 1000 is >> 38
    localparam logic [31:0] RECIP_125 = 32'd274877907;
    localparam logic [31:0] MM_PER_M  = 32'd1000;

    typedef struct packed {
        logic [19:0] wheel_scale;
        logic [19:0] yaw_gain;
        logic [11:0] lever_arm_mm;
        logic [14:0] limit_vx;
        logic [14:0] limit_vy;
        logic [14:0] limit_yaw;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_VX,
        ST_VY,
        ST_YAW_SC,
        ST_YAW_LO,
        ST_YAW_HI,
        ST_YAW_SUM,
        ST_ODO_X,
        ST_ODO_Y,
        ST_ROT_ABS,
        ST_DIV,
        ST_REM,
        ST_REM_CHK,
        ST_WHEEL,
        ST_DONE
    } state_t;

    // operand pair fed to the shared multiplier
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_VX,
        MUL_VY,
        MUL_YAW_SC,
        MUL_YAW_LO,
        MUL_YAW_HI,
        MUL_ODO_X,
        MUL_ODO_Y,
        MUL_ROT,
        MUL_DIV,
        MUL_REM
    } mul_sel_t;

    typedef struct packed {
        logic     take;
        mul_sel_t mul_sel;
        logic     ld_mvx;
        logic     ld_mvy;
        logic     ld_hi;
        logic     ld_ylo;
        logic     ld_ysum;
        logic     ld_odx;
        logic     ld_myaw;
        logic     ld_ody;
        logic     ld_rabs;
        logic     ld_fr;
        logic     ld_nz;
        logic     ld_wheel;
    } ctrl_t;

endpackage

// ===== rtl/mdk_cfg.sv =====
// configuration register file of the mecanum drive kinematics block
module mdk_cfg import mdk_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wheel_scale  <= RST_WHEEL_SCALE;
            cfg_reg.yaw_gain     <= RST_YAW_GAIN;
            cfg_reg.lever_arm_mm <= RST_LEVER_ARM_MM;
            cfg_reg.limit_vx     <= RST_LIMIT;
            cfg_reg.limit_vy     <= RST_LIMIT;
            cfg_reg.limit_yaw    <= RST_LIMIT;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_WHEEL_SCALE:  cfg_reg.wheel_scale  <= wr_data;
                REG_YAW_GAIN:     cfg_reg.yaw_gain     <= wr_data;
                REG_LEVER_ARM_MM: cfg_reg.lever_arm_mm <= wr_data[11:0];
                REG_LIMIT_VX:     cfg_reg.limit_vx     <= wr_data[14:0];
                REG_LIMIT_VY:     cfg_reg.limit_vy     <= wr_data[14:0];
                REG_LIMIT_YAW:    cfg_reg.limit_yaw    <= wr_data[14:0];
                default:          ; // unmapped index, write dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/mdk_mul.sv =====
// shared 32x32 signed multiplier with registered product
module mdk_mul import mdk_pkg::*; (
    input  logic               clk,
    input  logic signed [31:0] op_a,
    input  logic signed [31:0] op_b,
    output logic signed [63:0] prod
);

    logic signed [63:0] prod_next;
    logic signed [63:0] prod_reg;

    assign prod_next = op_a * op_b;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/mdk_seq.sv =====
// step sequencer: walks one tick through the shared multiplier
module mdk_seq import mdk_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  out_stall,
    input  logic  stop_req,
    output logic  in_stall,
    output logic  out_valid,
    output ctrl_t ctrl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = stop_req ? ST_DONE : ST_VX;
                end
            end
            ST_VX:      state_next = ST_VY;
            ST_VY:      state_next = ST_YAW_SC;
            ST_YAW_SC:  state_next = ST_YAW_LO;
            ST_YAW_LO:  state_next = ST_YAW_HI;
            ST_YAW_HI:  state_next = ST_YAW_SUM;
            ST_YAW_SUM: state_next = ST_ODO_X;
            ST_ODO_X:   state_next = ST_ODO_Y;
            ST_ODO_Y:   state_next = ST_ROT_ABS;
            ST_ROT_ABS: state_next = ST_DIV;
            ST_DIV:     state_next = ST_REM;
            ST_REM:     state_next = ST_REM_CHK;
            ST_REM_CHK: state_next = ST_WHEEL;
            ST_WHEEL:   state_next = ST_DONE;
            ST_DONE:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        ctrl         = '0;
        ctrl.mul_sel = MUL_NONE;
        in_stall     = 1'b1;
        out_valid    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                ctrl.take = in_valid;
            end
            ST_VX:      ctrl.mul_sel = MUL_VX;
            ST_VY:
            begin
                ctrl.mul_sel = MUL_VY;
                ctrl.ld_mvx  = 1'b1;
            end
            ST_YAW_SC:
            begin
                ctrl.mul_sel = MUL_YAW_SC;
                ctrl.ld_mvy  = 1'b1;
            end
            ST_YAW_LO:
            begin
                ctrl.mul_sel = MUL_YAW_LO;
                ctrl.ld_hi   = 1'b1;
            end
            ST_YAW_HI:
            begin
                ctrl.mul_sel = MUL_YAW_HI;
                ctrl.ld_ylo  = 1'b1;
            end
            ST_YAW_SUM:
            begin
                ctrl.mul_sel = MUL_ODO_X;
                ctrl.ld_ysum = 1'b1;
            end
            ST_ODO_X:
            begin
                ctrl.mul_sel = MUL_ODO_Y;
                ctrl.ld_odx  = 1'b1;
                ctrl.ld_myaw = 1'b1;
            end
            ST_ODO_Y:
            begin
                ctrl.mul_sel = MUL_ROT;
                ctrl.ld_ody  = 1'b1;
            end
            ST_ROT_ABS: ctrl.ld_rabs = 1'b1;
            ST_DIV:     ctrl.mul_sel = MUL_DIV;
            ST_REM:
            begin
                ctrl.mul_sel = MUL_REM;
                ctrl.ld_fr   = 1'b1;
            end
            ST_REM_CHK: ctrl.ld_nz    = 1'b1;
            ST_WHEEL:   ctrl.ld_wheel = 1'b1;
            ST_DONE:    out_valid     = 1'b1;
            default:    ;
        endcase
    end

endmodule

// ===== rtl/mecanum_drive_kinematics.sv =====
// top level of the mecanum drive kinematics block: datapath around the shared multiplier
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------------------
//   cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data (always ready)
//   in       | in_valid / in_stall    | count_a..count_d, target_vx, target_vy, target_yaw
//   out      | out_valid / out_stall  | meas_*, wheel_target_a..d, position_x/y, stopped
//
// an active tick walks 13 sequencer steps, which feed the ten products of the tick
// through the one 32x32 multiplier; the done state then shows the result until it is
// taken, and the sequencer returns to idle. a stop tick goes from idle straight to done.
// one tick at a time: in_stall stays high from the input transfer until the result
// transfer. reset clears the sequencer, odometry, last measured speeds and config registers.
// a stalled result holds its payload until out_stall drops.
module mecanum_drive_kinematics import mdk_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // tick input
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic signed [15:0]    count_a,
    input  logic signed [15:0]    count_b,
    input  logic signed [15:0]    count_c,
    input  logic signed [15:0]    count_d,
    input  logic signed [15:0]    target_vx,
    input  logic signed [15:0]    target_vy,
    input  logic signed [15:0]    target_yaw,
    // tick result
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [15:0]    meas_vx,
    output logic signed [15:0]    meas_vy,
    output logic signed [15:0]    meas_yaw,
    output logic signed [17:0]    wheel_target_a,
    output logic signed [17:0]    wheel_target_b,
    output logic signed [17:0]    wheel_target_c,
    output logic signed [17:0]    wheel_target_d,
    output logic signed [47:0]    position_x,
    output logic signed [47:0]    position_y,
    output logic                  stopped
);

    // saturate to 16 bits
    function automatic logic [15:0] sat16(input logic signed [23:0] v);
        if (v > 24'sd32767)
            sat16 = 16'h7fff;
        else if (v < -24'sd32768)
            sat16 = 16'h8000;
        else
            sat16 = v[15:0];
    endfunction

    // saturate to 18 bits
    function automatic logic [17:0] sat18(input logic signed [19:0] v);
        if (v > 20'sd131071)
            sat18 = 18'h1ffff;
        else if (v < -20'sd131072)
            sat18 = 18'h20000;
        else
            sat18 = v[17:0];
    endfunction

    // clamp to [-lim, +lim]
    function automatic logic [15:0] clamp_mag(input logic signed [15:0] v,
                                              input logic [14:0] lim);
        logic signed [16:0] lim_p;
        logic signed [16:0] lim_n;
        logic signed [16:0] v_x;
        lim_p = $signed({2'b00, lim});
        lim_n = -lim_p;
        v_x   = {v[15], v};
        if (v_x > lim_p)
            clamp_mag = lim_p[15:0];
        else if (v_x < lim_n)
            clamp_mag = lim_n[15:0];
        else
            clamp_mag = v;
    endfunction

    // trunc((1000*u + R) / 1000), with |R| = 1000*fr + rem and nz = (rem != 0)
    function automatic logic [19:0] wheel_mix(input logic signed [19:0] b_plus,
                                              input logic signed [19:0] b_minus,
                                              input logic r_pos,
                                              input logic nz);
        if (r_pos)
            wheel_mix = b_plus + {19'd0, (b_plus < 20'sd0) && nz};
        else
            wheel_mix = b_minus - {19'd0, (b_minus > 20'sd0) && nz};
    endfunction

    cfg_t  cfg;
    ctrl_t ctrl;
    logic  stop_req;

    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] prod;

    // tick operands, captured at the input transfer
    logic signed [17:0] ca_x, cb_x, cc_x, cd_x;
    logic signed [17:0] sum0_next, sum1_next, sum2_next;
    logic signed [17:0] sum0_reg, sum1_reg, sum2_reg;
    logic signed [15:0] tx_reg, ty_reg, tw_reg;

    // measured speeds, also the last measured state
    logic signed [15:0] mvx_reg, mvy_reg, myaw_reg;
    logic signed [15:0] mvx_next, mvy_next, myaw_next;
    logic [16:0]        mvx_abs, mvy_abs;
    logic signed [16:0] mvx_x, mvy_x;

    // yaw product split
    logic [6:0]         hi_reg;
    logic [50:0]        ylo_reg;
    logic [57:0]        ysum_reg, ysum_next;

    // odometry
    logic signed [47:0] odo_x_reg, odo_y_reg;
    logic signed [47:0] odo_x_next, odo_y_next;
    logic [20:0]        odo_q;

    // lever arm term and its division by 1000
    logic               r_neg_reg;
    logic [27:0]        rabs_reg, rabs_next;
    logic [17:0]        fr_reg;
    logic               nz_reg;

    // wheel targets
    logic signed [17:0] wa_reg, wb_reg, wc_reg, wd_reg;
    logic signed [17:0] wa_next, wb_next, wc_next, wd_next;
    logic               stopped_reg;

    // trunc toward zero for the measured speeds
    logic signed [23:0] vx_trunc, vy_trunc, yaw_trunc;

    assign cfg_ready = 1'b1;

    mdk_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign stop_req = (target_vx == 16'sd0) && (target_vy == 16'sd0)
                   && (target_yaw == 16'sd0);

    mdk_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .stop_req  (stop_req),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .ctrl      (ctrl)
    );

    // wheel sums of encoder counts; wheels A and C run mirrored
    assign ca_x = {{2{count_a[15]}}, count_a};
    assign cb_x = {{2{count_b[15]}}, count_b};
    assign cc_x = {{2{count_c[15]}}, count_c};
    assign cd_x = {{2{count_d[15]}}, count_d};

    assign sum0_next = cb_x + cd_x - ca_x - cc_x;  // forward
    assign sum1_next = ca_x + cb_x - cc_x - cd_x;  // sideways
    assign sum2_next = ca_x + cb_x + cc_x + cd_x;  // rotation

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = 32'sd0;
        mul_b = 32'sd0;
        unique case (ctrl.mul_sel)
            MUL_NONE:
            begin
                mul_a = 32'sd0;
                mul_b = 32'sd0;
            end
            MUL_VX:
            begin
                mul_a = {{14{sum0_reg[17]}}, sum0_reg};
                mul_b = {12'd0, cfg.wheel_scale};
            end
            MUL_VY:
            begin
                mul_a = {{14{sum1_reg[17]}}, sum1_reg};
                mul_b = {12'd0, cfg.wheel_scale};
            end
            MUL_YAW_SC:
            begin
                mul_a = {{14{sum2_reg[17]}}, sum2_reg};
                mul_b = {12'd0, cfg.wheel_scale};
            end
            MUL_YAW_LO:
            begin
                // low 31 bits of the scaled rotation sum, taken unsigned
                mul_a = {1'b0, prod[30:0]};
                mul_b = {12'd0, cfg.yaw_gain};
            end
            MUL_YAW_HI:
            begin
                mul_a = {{25{hi_reg[6]}}, hi_reg};
                mul_b = {12'd0, cfg.yaw_gain};
            end
            MUL_ODO_X:
            begin
                // |m| * 65536 / 2000 = (|m| << 12) / 125
                mul_a = {3'd0, mvx_abs, 12'd0};
                mul_b = RECIP_125;
            end
            MUL_ODO_Y:
            begin
                mul_a = {3'd0, mvy_abs, 12'd0};
                mul_b = RECIP_125;
            end
            MUL_ROT:
            begin
                mul_a = {{16{tw_reg[15]}}, tw_reg};
                mul_b = {20'd0, cfg.lever_arm_mm};
            end
            MUL_DIV:
            begin
                mul_a = {4'd0, rabs_reg};
                mul_b = RECIP_125;
            end
            MUL_REM:
            begin
                // quotient back times 1000 to spot a remainder
                mul_a = {14'd0, prod[55:38]};
                mul_b = MM_PER_M;
            end
            default:
            begin
                mul_a = 32'sd0;
                mul_b = 32'sd0;
            end
        endcase
    end

    mdk_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // scaled sums over 2^18, toward zero, then saturated
    assign vx_trunc  = {{4{prod[37]}}, prod[37:18]} + {23'd0, prod[37] && (|prod[17:0])};
    assign vy_trunc  = vx_trunc;
    assign mvx_next  = sat16(vx_trunc);
    assign mvy_next  = sat16(vy_trunc);

    // rotation: high partial product shifted up plus the unsigned low one
    assign ysum_next = {prod[26:0], 31'd0} + {7'd0, ylo_reg};
    assign yaw_trunc = ysum_reg[57:34] + {23'd0, ysum_reg[57] && (|ysum_reg[33:0])};
    assign myaw_next = sat16(yaw_trunc);

    // odometry steps: subtract the signed quotient
    assign mvx_x   = {mvx_reg[15], mvx_reg};
    assign mvy_x   = {mvy_reg[15], mvy_reg};
    assign mvx_abs = mvx_x[16] ? 17'(-mvx_x) : 17'(mvx_x);
    assign mvy_abs = mvy_x[16] ? 17'(-mvy_x) : 17'(mvy_x);
    assign odo_q   = prod[55:35];

    assign odo_x_next = mvx_reg[15] ? odo_x_reg + {27'd0, odo_q} : odo_x_reg - {27'd0, odo_q};
    assign odo_y_next = mvy_reg[15] ? odo_y_reg + {27'd0, odo_q} : odo_y_reg - {27'd0, odo_q};

    // magnitude of yaw * lever arm
    assign rabs_next = prod[27] ? 28'(-prod[27:0]) : prod[27:0];

    // inverse mix: 1000*(vx +- vy) +- yaw*lever, over 1000
    logic signed [16:0] u_minus, u_plus;
    logic signed [19:0] um_x, up_x, fr_x;

    assign u_minus = {tx_reg[15], tx_reg} - {ty_reg[15], ty_reg};
    assign u_plus  = {tx_reg[15], tx_reg} + {ty_reg[15], ty_reg};
    assign um_x    = {{3{u_minus[16]}}, u_minus};
    assign up_x    = {{3{u_plus[16]}}, u_plus};
    assign fr_x    = {2'd0, fr_reg};

    assign wa_next = sat18(wheel_mix(um_x + fr_x, um_x - fr_x, r_neg_reg, nz_reg));
    assign wb_next = sat18(wheel_mix(up_x + fr_x, up_x - fr_x, !r_neg_reg, nz_reg));
    assign wc_next = sat18(wheel_mix(up_x + fr_x, up_x - fr_x, r_neg_reg, nz_reg));
    assign wd_next = sat18(wheel_mix(um_x + fr_x, um_x - fr_x, !r_neg_reg, nz_reg));

    // architectural state: odometry and last measured speeds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            odo_x_reg <= '0;
            odo_y_reg <= '0;
            mvx_reg   <= '0;
            mvy_reg   <= '0;
            myaw_reg  <= '0;
        end
        else
        begin
            if (ctrl.ld_odx)
                odo_x_reg <= odo_x_next;
            if (ctrl.ld_ody)
                odo_y_reg <= odo_y_next;
            if (ctrl.ld_mvx)
                mvx_reg <= mvx_next;
            if (ctrl.ld_mvy)
                mvy_reg <= mvy_next;
            if (ctrl.ld_myaw)
                myaw_reg <= myaw_next;
        end
    end

    // working and result payload
    always_ff @(posedge clk)
    begin
        if (ctrl.take)
        begin
            sum0_reg    <= sum0_next;
            sum1_reg    <= sum1_next;
            sum2_reg    <= sum2_next;
            tx_reg      <= clamp_mag(target_vx, cfg.limit_vx);
            ty_reg      <= clamp_mag(target_vy, cfg.limit_vy);
            tw_reg      <= clamp_mag(target_yaw, cfg.limit_yaw);
            stopped_reg <= stop_req;
            if (stop_req)
            begin
                wa_reg <= '0;
                wb_reg <= '0;
                wc_reg <= '0;
                wd_reg <= '0;
            end
        end
        if (ctrl.ld_hi)
            hi_reg <= prod[37:31];
        if (ctrl.ld_ylo)
            ylo_reg <= prod[50:0];
        if (ctrl.ld_ysum)
            ysum_reg <= ysum_next;
        if (ctrl.ld_rabs)
        begin
            rabs_reg  <= rabs_next;
            r_neg_reg <= prod[27];
        end
        if (ctrl.ld_fr)
            fr_reg <= prod[55:38];
        if (ctrl.ld_nz)
            nz_reg <= (prod[27:0] != rabs_reg);
        if (ctrl.ld_wheel)
        begin
            wa_reg <= wa_next;
            wb_reg <= wb_next;
            wc_reg <= wc_next;
            wd_reg <= wd_next;
        end
    end

    assign meas_vx        = mvx_reg;
    assign meas_vy        = mvy_reg;
    assign meas_yaw       = myaw_reg;
    assign wheel_target_a = wa_reg;
    assign wheel_target_b = wb_reg;
    assign wheel_target_c = wc_reg;
    assign wheel_target_d = wd_reg;
    assign position_x     = odo_x_reg;
    assign position_y     = odo_y_reg;
    assign stopped        = stopped_reg;

endmodule

// ===== rtl/mdk_chk.sv =====
// port-level assertions for the mecanum drive kinematics block, with bind
module mdk_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic               stopped,
    input logic signed [15:0] meas_vx,
    input logic signed [17:0] wheel_target_a,
    input logic signed [17:0] wheel_target_b,
    input logic signed [17:0] wheel_target_c,
    input logic signed [17:0] wheel_target_d,
    input logic signed [47:0] position_x
);

    // busy right after an input transfer
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a tick is in flight");

    // one result per tick
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |=> !out_valid)
        else $error("result shown twice");

    // no new input while a result waits
    a_result_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while a result waits");

    // stop tick drives all wheel targets to zero
    a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stopped |-> wheel_target_a == 18'sd0 && wheel_target_b == 18'sd0
                              && wheel_target_c == 18'sd0 && wheel_target_d == 18'sd0)
        else $error("stop tick with nonzero wheel target");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(position_x) && $stable(meas_vx))
        else $error("stalled result changed");

endmodule

bind mecanum_drive_kinematics mdk_chk u_mdk_chk (.*);

// ===== tb/sv/mecanum_drive_kinematics_test.sv =====
// self-checking testbench for the mecanum drive kinematics block
`timescale 1ns / 1ps

module mecanum_drive_kinematics_test;
    import mdk_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 11;
    // drain time after the last report, to let the block settle
    localparam int DRAIN_CYCLES = 24;
    localparam int IDLE_LIMIT   = 60000;
    localparam int LONG_HOLD    = 400;
    localparam int MAX_REPORTS  = 40;

    localparam logic [15:0] MAX16 = 16'h7FFF;
    localparam logic [15:0] MIN16 = 16'h8000;

    // indexes past the last register, writes to them must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [15:0] count_a;
        logic [15:0] count_b;
        logic [15:0] count_c;
        logic [15:0] count_d;
        logic [15:0] target_vx;
        logic [15:0] target_vy;
        logic [15:0] target_yaw;
    } tick_t;

    typedef struct packed {
        logic [15:0] meas_vx;
        logic [15:0] meas_vy;
        logic [15:0] meas_yaw;
        logic [17:0] wheel_a;
        logic [17:0] wheel_b;
        logic [17:0] wheel_c;
        logic [17:0] wheel_d;
        logic [47:0] pos_x;
        logic [47:0] pos_y;
        logic        stopped;
    } tick_report_t;

    typedef enum logic [1:0] {
        STALL_OFF,
        STALL_LIGHT,
        STALL_HEAVY
    } stall_mode_t;

    // clock, reset and every block input start at a known value
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic               in_valid   = 1'b0;
    logic               in_stall;
    logic signed [15:0] count_a    = '0;
    logic signed [15:0] count_b    = '0;
    logic signed [15:0] count_c    = '0;
    logic signed [15:0] count_d    = '0;
    logic signed [15:0] target_vx  = '0;
    logic signed [15:0] target_vy  = '0;
    logic signed [15:0] target_yaw = '0;

    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] meas_vx;
    logic signed [15:0] meas_vy;
    logic signed [15:0] meas_yaw;
    logic signed [17:0] wheel_target_a;
    logic signed [17:0] wheel_target_b;
    logic signed [17:0] wheel_target_c;
    logic signed [17:0] wheel_target_d;
    logic signed [47:0] position_x;
    logic signed [47:0] position_y;
    logic               stopped;

    // register copies kept by the testbench
    logic [19:0] cfg_scale     = RST_WHEEL_SCALE;
    logic [19:0] cfg_yaw_gain  = RST_YAW_GAIN;
    logic [11:0] cfg_lever     = RST_LEVER_ARM_MM;
    logic [14:0] cfg_limit_vx  = RST_LIMIT;
    logic [14:0] cfg_limit_vy  = RST_LIMIT;
    logic [14:0] cfg_limit_yaw = RST_LIMIT;

    // kinematics state: odometry and the speeds reported on stop ticks
    logic [47:0] odom_x = '0;
    logic [47:0] odom_y = '0;
    logic [15:0] last_meas [3] = '{16'd0, 16'd0, 16'd0};

    tick_t        tick_backlog [$];   // ticks waiting to be offered
    tick_report_t tick_reports [$];   // predicted reports, oldest first
    tick_t        offered_tick;

    int unsigned mismatch_count = 0;
    int unsigned burst_left     = 0;
    int unsigned sender_gap     = 0;

    logic        hold_start = 1'b0;
    int unsigned hold_left  = 0;
    stall_mode_t stall_mode = STALL_OFF;
    int unsigned stall_mode_left = 0;

    mecanum_drive_kinematics dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .count_a        (count_a),
        .count_b        (count_b),
        .count_c        (count_c),
        .count_d        (count_d),
        .target_vx      (target_vx),
        .target_vy      (target_vy),
        .target_yaw     (target_yaw),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .meas_vx        (meas_vx),
        .meas_vy        (meas_vy),
        .meas_yaw       (meas_yaw),
        .wheel_target_a (wheel_target_a),
        .wheel_target_b (wheel_target_b),
        .wheel_target_c (wheel_target_c),
        .wheel_target_d (wheel_target_d),
        .position_x     (position_x),
        .position_y     (position_y),
        .stopped        (stopped)
    );

    always
    begin
        clk = 1'b1;
        #HALF_PERIOD;
        clk = 1'b0;
        #HALF_PERIOD;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    function automatic longint saturate(input longint v, input int unsigned bits);
        longint hi;
        longint lo;
        hi = (longint'(1) << (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    function automatic longint clamp_mag(input longint v, input longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // one control tick: updates odometry and last speeds, returns the report
    function automatic tick_report_t step_kinematics(input tick_t t);
        tick_report_t r;
        longint sc, wa, wb, wc, wd;
        longint mvx, mvy, myaw;
        longint tx, ty, tw, fx, fy, rot;
        r = '0;
        if (t.target_vx == 16'd0 && t.target_vy == 16'd0 && t.target_yaw == 16'd0)
        begin
            // stop tick: counts ignored, nothing moves
            r.meas_vx  = last_meas[0];
            r.meas_vy  = last_meas[1];
            r.meas_yaw = last_meas[2];
            r.stopped  = 1'b1;
        end
        else
        begin
            sc = longint'(cfg_scale);
            // wheels a and c are mounted mirrored
            wa = -(longint'($signed(t.count_a)) * sc);
            wb =   longint'($signed(t.count_b)) * sc;
            wc = -(longint'($signed(t.count_c)) * sc);
            wd =   longint'($signed(t.count_d)) * sc;

            mvx  = saturate((wa + wb + wc + wd) / (longint'(1) << 18), 16);
            mvy  = saturate((-wa + wb + wc - wd) / (longint'(1) << 18), 16);
            myaw = saturate(((-wa + wb - wc + wd) * longint'(cfg_yaw_gain))
                            / (longint'(1) << 34), 16);
            last_meas[0] = mvx[15:0];
            last_meas[1] = mvy[15:0];
            last_meas[2] = myaw[15:0];

            // q16 odometry step, wraps at 48 bits
            fx = (mvx * 65536) / 2000;
            fy = (mvy * 65536) / 2000;
            odom_x = odom_x - fx[47:0];
            odom_y = odom_y - fy[47:0];

            // clamp on the raw targets, then the inverse mix
            tx  = clamp_mag(longint'($signed(t.target_vx)), longint'(cfg_limit_vx));
            ty  = clamp_mag(longint'($signed(t.target_vy)), longint'(cfg_limit_vy));
            tw  = clamp_mag(longint'($signed(t.target_yaw)), longint'(cfg_limit_yaw));
            rot = tw * longint'(cfg_lever);
            fx  = 1000 * tx;
            fy  = 1000 * ty;
            wa  = saturate((fx - fy - rot) / 1000, 18);
            wb  = saturate((fx + fy + rot) / 1000, 18);
            wc  = saturate((fx + fy - rot) / 1000, 18);
            wd  = saturate((fx - fy + rot) / 1000, 18);

            r.meas_vx  = mvx[15:0];
            r.meas_vy  = mvy[15:0];
            r.meas_yaw = myaw[15:0];
            r.wheel_a  = wa[17:0];
            r.wheel_b  = wb[17:0];
            r.wheel_c  = wc[17:0];
            r.wheel_d  = wd[17:0];
            r.stopped  = 1'b0;
        end
        r.pos_x = odom_x;
        r.pos_y = odom_y;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [47:0] got,
                               input logic [47:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    task automatic check_report(input tick_report_t got, input tick_report_t want);
        check_field("meas_vx",        got.meas_vx,  want.meas_vx);
        check_field("meas_vy",        got.meas_vy,  want.meas_vy);
        check_field("meas_yaw",       got.meas_yaw, want.meas_yaw);
        check_field("wheel_target_a", got.wheel_a,  want.wheel_a);
        check_field("wheel_target_b", got.wheel_b,  want.wheel_b);
        check_field("wheel_target_c", got.wheel_c,  want.wheel_c);
        check_field("wheel_target_d", got.wheel_d,  want.wheel_d);
        check_field("position_x",     got.pos_x,    want.pos_x);
        check_field("position_y",     got.pos_y,    want.pos_y);
        check_field("stopped",        got.stopped,  want.stopped);
    endtask

    // ------------------------------------------------------------------
    // tick driver: bursts of transfers with random gaps between them
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : drive_ticks
        logic offer;
        offer = in_valid;
        if (rst_n && in_valid && !in_stall)
        begin
            // tick transfer, predict its report now
            tick_reports.push_back(step_kinematics(offered_tick));
            offer = 1'b0;
        end
        if (rst_n && !offer)
        begin
            if (sender_gap != 0)
                sender_gap--;
            else if (tick_backlog.size() != 0)
            begin
                offered_tick = tick_backlog.pop_front();
                count_a    <= offered_tick.count_a;
                count_b    <= offered_tick.count_b;
                count_c    <= offered_tick.count_c;
                count_d    <= offered_tick.count_d;
                target_vx  <= offered_tick.target_vx;
                target_vy  <= offered_tick.target_vy;
                target_yaw <= offered_tick.target_yaw;
                offer = 1'b1;
                if (burst_left != 0)
                    burst_left--;
                else
                begin
                    // end of burst: pick the next burst and the pause before it
                    burst_left = $urandom_range(0, 16);
                    sender_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40)
                                                             : $urandom_range(0, 4);
                end
            end
        end
        in_valid <= offer;
    end

    // ------------------------------------------------------------------
    // result monitor and receiver stall pattern
    // ------------------------------------------------------------------

    // long hold-off counted here, started by a pulse on hold_start
    always @(posedge clk)
    begin
        if (hold_start)
            hold_left <= LONG_HOLD;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin : watch_reports
        tick_report_t seen;
        logic         hold;
        if (rst_n && out_valid && !out_stall)
        begin
            seen.meas_vx  = meas_vx;
            seen.meas_vy  = meas_vy;
            seen.meas_yaw = meas_yaw;
            seen.wheel_a  = wheel_target_a;
            seen.wheel_b  = wheel_target_b;
            seen.wheel_c  = wheel_target_c;
            seen.wheel_d  = wheel_target_d;
            seen.pos_x    = position_x;
            seen.pos_y    = position_y;
            seen.stopped  = stopped;
            if (tick_reports.size() == 0)
                report_mismatch("result transfer with no tick outstanding");
            else
                check_report(seen, tick_reports.pop_front());
        end

        // stall mode is redrawn when its countdown runs out, off mode gives clean stretches
        if (stall_mode_left == 0)
        begin
            stall_mode      = stall_mode_t'($urandom_range(0, 2));
            stall_mode_left = $urandom_range(16, 120);
        end
        else
            stall_mode_left--;

        case (stall_mode)
            STALL_LIGHT: hold = ($urandom_range(0, 3) == 0);
            STALL_HEAVY: hold = ($urandom_range(0, 3) != 0);
            default:     hold = 1'b0;
        endcase
        out_stall <= hold || (hold_left != 0);
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    function automatic logic [15:0] random_word();
        case ($urandom_range(0, 11))
            0:       return MAX16;
            1:       return MIN16;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            4:       return 16'h0001;
            5, 6, 7: return 16'($urandom_range(0, 600) - 300);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic tick_t random_tick();
        tick_t t;
        t.count_a    = random_word();
        t.count_b    = random_word();
        t.count_c    = random_word();
        t.count_d    = random_word();
        t.target_vx  = random_word();
        t.target_vy  = random_word();
        t.target_yaw = random_word();
        case ($urandom_range(0, 7))
            // stop tick, counts still random
            0:
            begin
                t.target_vx  = 16'd0;
                t.target_vy  = 16'd0;
                t.target_yaw = 16'd0;
            end
            // only the yaw target left random, so it may be nonzero
            1:
            begin
                t.target_vx = 16'd0;
                t.target_vy = 16'd0;
            end
            default: ;
        endcase
        return t;
    endfunction

    task automatic queue_tick(input logic [15:0] a, input logic [15:0] b,
                              input logic [15:0] c, input logic [15:0] d,
                              input logic [15:0] vx, input logic [15:0] vy,
                              input logic [15:0] yaw);
        tick_backlog.push_back('{a, b, c, d, vx, vy, yaw});
    endtask

    task automatic queue_random(input int unsigned n);
        repeat (n)
            tick_backlog.push_back(random_tick());
    endtask

    // register write; the copy is updated once the transfer has happened
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_WHEEL_SCALE:  cfg_scale     = value[19:0];
            REG_YAW_GAIN:     cfg_yaw_gain  = value[19:0];
            REG_LEVER_ARM_MM: cfg_lever     = value[11:0];
            REG_LIMIT_VX:     cfg_limit_vx  = value[14:0];
            REG_LIMIT_VY:     cfg_limit_vy  = value[14:0];
            REG_LIMIT_YAW:    cfg_limit_yaw = value[14:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // sender pauses until every tick is sent and every report is back
    // checked at the falling edge, once the rising-edge updates have settled
    task automatic wait_idle();
        int unsigned waited;
        waited = 0;
        while ((tick_backlog.size() != 0 || in_valid || tick_reports.size() != 0)
               && waited < IDLE_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tick_reports.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", tick_reports.size()));
            tick_reports.delete();
        end
    endtask

    task automatic random_registers();
        write_register(REG_WHEEL_SCALE,  20'($urandom));
        write_register(REG_YAW_GAIN,     20'($urandom));
        write_register(REG_LEVER_ARM_MM, 20'($urandom));
        write_register(REG_LIMIT_VX,     20'($urandom));
        write_register(REG_LIMIT_VY,     20'($urandom));
        write_register(REG_LIMIT_YAW,    20'($urandom));
        if ($urandom_range(0, 1) == 0)
            write_register(REG_SPARE_7, 20'($urandom));
    endtask

    initial
    begin : run_phases
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers at reset values
        queue_tick(16'd1234, 16'hFFFB, MAX16, MIN16, 16'd0, 16'd0, 16'd0); // stop before any motion
        queue_tick(MAX16, MAX16, MAX16, MAX16, MAX16, MAX16, MAX16);
        queue_tick(MIN16, MIN16, MIN16, MIN16, MIN16, MIN16, MIN16);
        queue_tick(MIN16, MAX16, MIN16, MAX16, 16'd1, 16'd0, 16'd0);       // largest forward
        queue_tick(MAX16, MAX16, MIN16, MIN16, 16'd0, 16'd1, 16'd0);       // largest sideways
        queue_tick(MAX16, MIN16, MAX16, MIN16, 16'd0, 16'd0, 16'hFFFF);
        queue_tick(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);       // stop repeats speeds
        queue_tick(16'h5555, 16'hAAAA, 16'h3333, 16'hCCCC, 16'h5555, 16'hAAAA, 16'h0F0F);
        queue_random(100);
        wait_idle();

        // every register at its top, limits written with bits past their width
        write_register(REG_WHEEL_SCALE,  20'hFFFFF);
        write_register(REG_YAW_GAIN,     20'hFFFFF);
        write_register(REG_LEVER_ARM_MM, 20'hFFFFF);
        write_register(REG_LIMIT_VX,     20'hFFFFF);
        write_register(REG_LIMIT_VY,     20'hFFFFF);
        write_register(REG_LIMIT_YAW,    20'hFFFFF);
        queue_tick(MIN16, MAX16, MIN16, MAX16, MAX16, MAX16, MAX16);       // saturate high
        queue_tick(MAX16, MIN16, MAX16, MIN16, MIN16, MIN16, MIN16);       // saturate low
        queue_tick(MAX16, MAX16, MAX16, MAX16, MAX16, MIN16, MAX16);
        queue_tick(16'h00FF, 16'hFF00, 16'd7, 16'd9, 16'd0, 16'd0, 16'd0);
        queue_random(80);
        wait_idle();

        // zero gains and limits: ticks that yield zero speeds and wheel targets
        write_register(REG_WHEEL_SCALE,  20'd0);
        write_register(REG_YAW_GAIN,     20'd0);
        write_register(REG_LEVER_ARM_MM, 20'd0);
        write_register(REG_LIMIT_VX,     20'd0);
        write_register(REG_LIMIT_VY,     20'd0);
        write_register(REG_LIMIT_YAW,    20'd0);
        write_register(REG_SPARE_6,      20'($urandom));
        queue_tick(MAX16, MIN16, 16'd1, 16'hFFFF, MAX16, MIN16, 16'd1);   // clamps to zero
        queue_tick(16'd1, 16'd2, 16'd3, 16'd4, 16'd0, 16'd0, 16'd0);
        queue_random(40);
        wait_idle();

        // plausible robot with tight limits, then a long receiver hold
        write_register(REG_WHEEL_SCALE,  20'($urandom_range(1000, 200000)));
        write_register(REG_YAW_GAIN,     RST_YAW_GAIN);
        write_register(REG_LEVER_ARM_MM, 20'($urandom_range(50, 400)));
        write_register(REG_LIMIT_VX,     20'd100);
        write_register(REG_LIMIT_VY,     20'd50);
        write_register(REG_LIMIT_YAW,    20'd1);
        queue_tick(16'd10, 16'hFFF6, 16'd20, 16'd5, 16'd500, 16'hFE0C, 16'd2);
        queue_tick(16'hFFEC, 16'd30, 16'd0, 16'hFFFF, 16'hFE0C, 16'd500, 16'hFFFE);
        queue_tick(16'd3, 16'd3, 16'd3, 16'd3, 16'd0, 16'd0, 16'd1);      // yaw only
        queue_random(150);
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        wait_idle();

        // fully random register settings
        repeat (3)
        begin
            random_registers();
            queue_random(80);
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("mecanum_drive_kinematics: match");
        else
            $display("mecanum_drive_kinematics: mismatch");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial
    begin
        #4000000;
        $display("mecanum_drive_kinematics: mismatch");
        $finish;
    end

endmodule

// ===== mecanum_drive_kinematics.f =====
rtl/mdk_pkg.sv
rtl/mdk_cfg.sv
rtl/mdk_mul.sv
rtl/mdk_seq.sv
rtl/mecanum_drive_kinematics.sv
rtl/mdk_chk.sv
tb/sv/mecanum_drive_kinematics_test.sv
